FILE: hw/rtl/rrg_pkg.sv
// Shared constants for the refraction ray generator.
`default_nettype none
package rrg_pkg;

   // Fixed field widths.
   localparam int IDX_W  = 16;
   localparam int PT_W   = 32;
   localparam int BIAS_W = 17;
   localparam int CSR_W  = 17;
   localparam int CSR_INDEX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_INDEX = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BIAS = 1'd1;

   // Register reset values.
   localparam logic [IDX_W-1:0]  OUTER_INDEX_RESET = 16'd4096;
   localparam logic [BIAS_W-1:0] OFFSET_BIAS_RESET = 17'd7;

endpackage
`default_nettype wire

FILE: hw/rtl/rrg_req_if.sv
// Request channel carrying one surface hit per transaction.
`default_nettype none
interface rrg_req_if #(parameter int DIR_FRAC_BITS = 16) ();
   logic                       valid;
   logic                       ready;
   logic [DIR_FRAC_BITS+1:0]   normal_x;
   logic [DIR_FRAC_BITS+1:0]   normal_y;
   logic [DIR_FRAC_BITS+1:0]   normal_z;
   logic [DIR_FRAC_BITS+1:0]   incident_x;
   logic [DIR_FRAC_BITS+1:0]   incident_y;
   logic [DIR_FRAC_BITS+1:0]   incident_z;
   logic [31:0]                hit_x;
   logic [31:0]                hit_y;
   logic [31:0]                hit_z;
   logic [15:0]                material_index;

   modport source (output valid, normal_x, normal_y, normal_z, incident_x, incident_y,
                   incident_z, hit_x, hit_y, hit_z, material_index, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, incident_x, incident_y,
                 incident_z, hit_x, hit_y, hit_z, material_index, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rrg_rsp_if.sv
// Response channel carrying one refracted ray per transaction.
`default_nettype none
interface rrg_rsp_if #(parameter int DIR_FRAC_BITS = 16) ();
   logic                       valid;
   logic                       ready;
   logic                       transmitted;
   logic [31:0]                origin_x;
   logic [31:0]                origin_y;
   logic [31:0]                origin_z;
   logic [DIR_FRAC_BITS+1:0]   dir_x;
   logic [DIR_FRAC_BITS+1:0]   dir_y;
   logic [DIR_FRAC_BITS+1:0]   dir_z;

   modport source (output valid, transmitted, origin_x, origin_y, origin_z, dir_x, dir_y,
                   dir_z, input ready);
   modport sink (input valid, transmitted, origin_x, origin_y, origin_z, dir_x, dir_y,
                 dir_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rrg_delay.sv
// Stall-aware delay line that carries side data and a valid bit.
`default_nettype none
module rrg_delay #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 1
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire logic     in_valid,
   input  wire data_type in_data,
   output      logic     out_valid,
   output      data_type out_data
);

   logic [DEPTH-1:0] valid_ff;
   data_type         data_ff [DEPTH];

   // Valid bits are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j < DEPTH; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   // Payload shifts with the valid bits.
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff[0] <= in_data;
         for (int j = 1; j < DEPTH; j++) begin
            data_ff[j] <= data_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rrg_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rrg_divider #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 32,
   parameter int QUO_W = 21
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output      logic [QUO_W-1:0] quotient,
   output      logic             overflow
);

   localparam int CW = NUM_W + DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic             ovf_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int SH = QUO_W - 1 - j;
      logic [NUM_W-1:0] rem_prev, rem_in;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] quo_prev, quo_in;
      logic             ovf_prev;
      logic [CW-1:0]    trial;
      logic             fits;

      // Stage inputs come from the ports or the previous stage.
      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
         assign ovf_prev = CW'(num) >= (CW'(den) << QUO_W);
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign ovf_prev = ovf_ff[j-1];
      end

      // Try to subtract the shifted divisor and record the quotient bit.
      always_comb begin
         trial  = CW'(den_prev) << SH;
         fits   = CW'(rem_prev) >= trial;
         rem_in = fits ? NUM_W'(CW'(rem_prev) - trial) : rem_prev;
         quo_in = quo_prev;
         quo_in[SH] = fits;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_prev;
            quo_ff[j] <= quo_in;
            ovf_ff[j] <= ovf_prev;
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];
   assign overflow = ovf_ff[QUO_W-1];

endmodule
`default_nettype wire

FILE: hw/rtl/rrg_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
`default_nettype none
module rrg_sqrt #(
   parameter int IN_W  = 36,
   parameter int OUT_W = 18
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [IN_W-1:0]  radicand,
   output      logic [OUT_W-1:0] root
);

   localparam int ITER = IN_W / 2;

   logic [IN_W-1:0] rem_ff  [ITER];
   logic [IN_W-1:0] root_ff [ITER];

   for (genvar j = 0; j < ITER; j++) begin : g_stage
      localparam int SH = ITER - 1 - j;
      logic [IN_W-1:0] rem_prev, root_prev, rem_in, root_in, bit_val;
      logic [IN_W:0]   trial;
      logic            fits;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      // Subtract root plus the current bit when it fits.
      always_comb begin
         bit_val = IN_W'(1) << (2 * SH);
         trial   = {1'b0, root_prev} + {1'b0, bit_val};
         fits    = {1'b0, rem_prev} >= trial;
         rem_in  = fits ? IN_W'({1'b0, rem_prev} - trial) : rem_prev;
         root_in = fits ? (root_prev >> 1) + bit_val : (root_prev >> 1);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign root = root_ff[ITER-1][OUT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/refraction_ray_generator_unit.sv
// Top level of the refraction ray generator: Snell's law transmission pipeline.
//
//   Channel   Port             Direction  Contents
//   request   req_if (sink)    in         normal, incident, hit point, material index
//   response  rsp_if (source)  out        transmitted flag, new origin, new direction
//   csr       csr_*            in         outer_index (0), offset_bias (1)
//
// One ray enters per cycle while the pipeline advances; a response transaction follows
// its request transaction through stages A to F, the quotient-bit stages of the
// dividers, stage G, the root-bit stages of the square root, stage H and the output stage.
// Reset clears all valid bits and loads the register defaults; payload is not reset.
// The whole pipeline advances together; it holds when the output register is full and
// the response side is not ready, so req_if.ready drops in that cycle.
`default_nettype none
module refraction_ray_generator_unit #(
   parameter int DIR_FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [rrg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rrg_pkg::CSR_W-1:0]         csr_write_data,
   rrg_req_if.sink                                req_if,
   rrg_rsp_if.source                              rsp_if
);

   localparam int F      = DIR_FRAC_BITS;
   localparam int DW     = F + 2;
   localparam int NV_W   = F + 3;
   localparam int PR_W   = 2 * F + 4;
   localparam int PP_W   = 2 * NV_W;
   localparam int DS_W   = F + 6;
   localparam int DM_W   = F + 2;
   localparam int D2_W   = F + 3;
   localparam int V_W    = F + 4;
   localparam int VM_W   = F + 3;
   localparam int S_W    = F + 4;
   localparam int MAG_W  = F + 2;
   localparam int SQ_W   = 2 * rrg_pkg::IDX_W;
   localparam int NUM_W  = SQ_W + MAG_W;
   localparam int DNUM_W = rrg_pkg::IDX_W + VM_W;
   localparam int QW     = F + 5;
   localparam int QS_W   = F + 4;
   localparam int K_W    = F + 5;
   localparam int X_W    = 2 * F + 4;
   localparam int T_W    = F + 6;
   localparam int T2_W   = F + 4;
   localparam int OFF_W  = 20;
   localparam int PT_W   = rrg_pkg::PT_W;
   localparam int IDX_W  = rrg_pkg::IDX_W;
   localparam int BIAS_W = rrg_pkg::BIAS_W;

   typedef struct packed {
      logic [2:0][DW-1:0]   nrm;
      logic [2:0][DW-1:0]   inc;
      logic [2:0][PT_W-1:0] hit;
      logic [IDX_W-1:0]     mat;
   } a_type;

   typedef struct packed {
      logic [2:0][DW-1:0]   inc;
      logic [2:0][DW-1:0]   nrm;
      logic [2:0][PT_W-1:0] hit;
      logic [IDX_W-1:0]     mat;
      logic [2:0][PR_W-1:0] prod;
   } b_type;

   typedef struct packed {
      logic [2:0][NV_W-1:0] nv;
      logic [2:0][DW-1:0]   inc;
      logic [2:0][PT_W-1:0] hit;
      logic [DM_W-1:0]      dmag;
      logic [IDX_W-1:0]     ni;
      logic [IDX_W-1:0]     nt;
   } c_type;

   typedef struct packed {
      logic [2:0][NV_W-1:0] nv;
      logic [2:0][DW-1:0]   inc;
      logic [2:0][PT_W-1:0] hit;
      logic [IDX_W-1:0]     ni;
      logic [IDX_W-1:0]     nt;
      logic [D2_W-1:0]      d2;
      logic [2:0][V_W-1:0]  dn;
   } d_type;

   typedef struct packed {
      logic [2:0][NV_W-1:0] nv;
      logic [2:0][PT_W-1:0] hit;
      logic [IDX_W-1:0]     ni;
      logic [IDX_W-1:0]     nt;
      logic                 s_neg;
      logic [MAG_W-1:0]     mag;
      logic [SQ_W-1:0]      nisq;
      logic [SQ_W-1:0]      ntsq;
      logic [2:0][VM_W-1:0] vmag;
      logic [2:0]           vneg;
   } e_type;

   typedef struct packed {
      logic [2:0][NV_W-1:0] nv;
      logic [2:0][PT_W-1:0] hit;
      logic                 s_neg;
      logic [2:0]           vneg;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [IDX_W-1:0]       nt;
      logic [NUM_W-1:0]       num;
      logic [SQ_W-1:0]        ntsq;
      logic [2:0][DNUM_W-1:0] dnum;
   } f_type;

   typedef struct packed {
      logic [2:0][NV_W-1:0] nv;
      logic [2:0][PT_W-1:0] hit;
      logic                 tir;
      logic [2:0][T_W-1:0]  term;
   } g_type;

   typedef struct packed {
      logic [2:0][PT_W-1:0]  hit;
      logic                  tir;
      logic [2:0][T_W-1:0]   term;
      logic [2:0][T2_W-1:0]  t2;
      logic [2:0][OFF_W-1:0] off;
   } h_type;

   // Configuration registers.
   logic [IDX_W-1:0]  outer_index_ff;
   logic [BIAS_W-1:0] offset_bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_index_ff <= rrg_pkg::OUTER_INDEX_RESET;
         offset_bias_ff <= rrg_pkg::OFFSET_BIAS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rrg_pkg::CSR_OUTER_INDEX: begin
               outer_index_ff <= csr_write_data[IDX_W-1:0];
            end
            rrg_pkg::CSR_OFFSET_BIAS: begin
               offset_bias_ff <= csr_write_data[BIAS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Global advance: every stage moves unless the output register is held.
   logic advance;
   logic out_valid_ff;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // Stage A: input register.
   a_type a_in, a_ff;
   logic  a_valid_ff;

   assign a_in.nrm = {req_if.normal_z, req_if.normal_y, req_if.normal_x};
   assign a_in.inc = {req_if.incident_z, req_if.incident_y, req_if.incident_x};
   assign a_in.hit = {req_if.hit_z, req_if.hit_y, req_if.hit_x};
   assign a_in.mat = req_if.material_index;

   // Stage B: component products of I and N.
   b_type b_in, b_ff;
   logic  b_valid_ff;

   always_comb begin
      b_in.inc = a_ff.inc;
      b_in.nrm = a_ff.nrm;
      b_in.hit = a_ff.hit;
      b_in.mat = a_ff.mat;
      for (int c = 0; c < 3; c++) begin
         b_in.prod[c] = PR_W'($signed(a_ff.inc[c])) * PR_W'($signed(a_ff.nrm[c]));
      end
   end

   // Stage C: dot product, side selection, index selection.
   c_type                 c_in, c_ff;
   logic                  c_valid_ff;
   logic signed [DS_W-1:0] dsum, dabs;
   logic                  enter;
   logic [IDX_W-1:0]      nt_raw;

   always_comb begin
      dsum = '0;
      for (int c = 0; c < 3; c++) begin
         dsum = dsum + DS_W'($signed(b_ff.prod[c]) >>> F);
      end
      enter = dsum[DS_W-1];
      dabs  = enter ? -dsum : dsum;
      c_in.dmag = (dabs > (DS_W'(1) << (F + 1))) ? (DM_W'(1) << (F + 1)) : DM_W'(dabs);
      for (int c = 0; c < 3; c++) begin
         c_in.nv[c] = enter ? NV_W'($signed(b_ff.nrm[c])) : -NV_W'($signed(b_ff.nrm[c]));
      end
      c_in.inc  = b_ff.inc;
      c_in.hit  = b_ff.hit;
      c_in.ni   = enter ? outer_index_ff : b_ff.mat;
      nt_raw    = enter ? b_ff.mat : outer_index_ff;
      c_in.nt   = (nt_raw == '0) ? IDX_W'(1) : nt_raw;
   end

   // Stage D: d squared and d times n.
   d_type                    d_in, d_ff;
   logic                     d_valid_ff;
   logic signed [NV_W-1:0]   dmag_s;
   logic [2*DM_W-1:0]        dsq;
   logic signed [PP_W-1:0]   dn_prod [3];

   always_comb begin
      dmag_s = $signed({1'b0, c_ff.dmag});
      dsq    = c_ff.dmag * c_ff.dmag;
      d_in.d2 = D2_W'(dsq >> F);
      for (int c = 0; c < 3; c++) begin
         dn_prod[c] = PP_W'(dmag_s) * PP_W'($signed(c_ff.nv[c]));
         d_in.dn[c] = V_W'(dn_prod[c] >>> F);
      end
      d_in.nv  = c_ff.nv;
      d_in.inc = c_ff.inc;
      d_in.hit = c_ff.hit;
      d_in.ni  = c_ff.ni;
      d_in.nt  = c_ff.nt;
   end

   // Stage E: s = 1 - d^2, squared indices, v = I + d*n.
   e_type                 e_in, e_ff;
   logic                  e_valid_ff;
   logic signed [S_W-1:0] s_val;
   logic signed [V_W-1:0] v_val [3];

   always_comb begin
      s_val = $signed((S_W'(1) << F) - S_W'(d_ff.d2));
      e_in.s_neg = s_val[S_W-1];
      e_in.mag   = MAG_W'(s_val[S_W-1] ? -s_val : s_val);
      e_in.nisq  = SQ_W'(d_ff.ni) * SQ_W'(d_ff.ni);
      e_in.ntsq  = SQ_W'(d_ff.nt) * SQ_W'(d_ff.nt);
      for (int c = 0; c < 3; c++) begin
         v_val[c]      = V_W'($signed(d_ff.inc[c])) + $signed(d_ff.dn[c]);
         e_in.vneg[c]  = v_val[c][V_W-1];
         e_in.vmag[c]  = VM_W'(v_val[c][V_W-1] ? -v_val[c] : v_val[c]);
      end
      e_in.nv  = d_ff.nv;
      e_in.hit = d_ff.hit;
      e_in.ni  = d_ff.ni;
      e_in.nt  = d_ff.nt;
   end

   // Stage F: dividends for the q and direction divisions.
   f_type f_in, f_ff;
   logic  f_valid_ff;

   always_comb begin
      f_in.side.nv    = e_ff.nv;
      f_in.side.hit   = e_ff.hit;
      f_in.side.s_neg = e_ff.s_neg;
      f_in.side.vneg  = e_ff.vneg;
      f_in.nt         = e_ff.nt;
      f_in.num        = NUM_W'(e_ff.nisq) * NUM_W'(e_ff.mag);
      f_in.ntsq       = e_ff.ntsq;
      for (int c = 0; c < 3; c++) begin
         f_in.dnum[c] = DNUM_W'(e_ff.ni) * DNUM_W'(e_ff.vmag[c]);
      end
   end

   // Division stages: q = ni^2 |s| / nt^2 and |ni v| / nt for each component.
   logic [QW-1:0] q_quo;
   logic          q_ovf;
   logic [QW-1:0] dq_quo [3];
   logic          dq_ovf [3];
   side_type      div_side;
   logic          div_valid;

   rrg_divider #(.NUM_W(NUM_W), .DEN_W(SQ_W), .QUO_W(QW)) u_q_div (
      .clock    (clock),
      .enable   (advance),
      .num      (f_ff.num),
      .den      (f_ff.ntsq),
      .quotient (q_quo),
      .overflow (q_ovf)
   );

   for (genvar c = 0; c < 3; c++) begin : g_dir_div
      rrg_divider #(.NUM_W(DNUM_W), .DEN_W(IDX_W), .QUO_W(QW)) u_dir_div (
         .clock    (clock),
         .enable   (advance),
         .num      (f_ff.dnum[c]),
         .den      (f_ff.nt),
         .quotient (dq_quo[c]),
         .overflow (dq_ovf[c])
      );
   end

   rrg_delay #(.data_type(side_type), .DEPTH(QW)) u_div_side (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (f_valid_ff),
      .in_data   (f_ff.side),
      .out_valid (div_valid),
      .out_data  (div_side)
   );

   // Stage G: k, the reflection test, and the scaled direction terms.
   g_type                 g_in, g_ff;
   logic                  g_valid_ff;
   logic [X_W-1:0]        x_in, x_ff;
   logic [QS_W-1:0]       q_sat;
   logic signed [K_W-1:0] k_val;
   logic [QW-1:0]         term_mag [3];

   always_comb begin
      q_sat = (q_ovf || (q_quo > (QW'(1) << (F + 3)))) ? (QS_W'(1) << (F + 3))
                                                      : QS_W'(q_quo);
      k_val = div_side.s_neg ? $signed((K_W'(1) << F) + K_W'(q_sat))
                             : $signed((K_W'(1) << F) - K_W'(q_sat));
      g_in.tir = k_val[K_W-1];
      x_in     = g_in.tir ? '0 : (X_W'(k_val) << F);
      for (int c = 0; c < 3; c++) begin
         term_mag[c] = (dq_ovf[c] || (dq_quo[c] > (QW'(1) << (F + 4))))
                       ? (QW'(1) << (F + 4)) : dq_quo[c];
         g_in.term[c] = div_side.vneg[c] ? -T_W'(term_mag[c]) : T_W'(term_mag[c]);
      end
      g_in.nv  = div_side.nv;
      g_in.hit = div_side.hit;
   end

   // Square root stages.
   logic [DW-1:0] sk;
   g_type         sq_side;
   logic          sq_valid;

   rrg_sqrt #(.IN_W(X_W), .OUT_W(DW)) u_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (x_ff),
      .root     (sk)
   );

   rrg_delay #(.data_type(g_type), .DEPTH(X_W / 2)) u_sqrt_side (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (g_valid_ff),
      .in_data   (g_ff),
      .out_valid (sq_valid),
      .out_data  (sq_side)
   );

   // Stage H: sqrt(k) times n and bias times n.
   h_type                    h_in, h_ff;
   logic                     h_valid_ff;
   logic signed [NV_W-1:0]   sk_s;
   logic signed [BIAS_W:0]   bias_s;
   logic signed [PP_W-1:0]   t2_prod [3];
   logic signed [PP_W-1:0]   off_prod [3];

   always_comb begin
      sk_s   = $signed({1'b0, sk});
      bias_s = $signed({1'b0, offset_bias_ff});
      for (int c = 0; c < 3; c++) begin
         t2_prod[c]  = PP_W'(sk_s) * PP_W'($signed(sq_side.nv[c]));
         off_prod[c] = PP_W'(bias_s) * PP_W'($signed(sq_side.nv[c]));
         h_in.t2[c]  = T2_W'(t2_prod[c] >>> F);
         h_in.off[c] = OFF_W'(off_prod[c] >>> F);
      end
      h_in.hit  = sq_side.hit;
      h_in.tir  = sq_side.tir;
      h_in.term = sq_side.term;
   end

   // Output stage: final subtraction and saturation.
   logic                   transmitted_in, transmitted_ff;
   logic [2:0][PT_W-1:0]   origin_in, origin_ff;
   logic [2:0][DW-1:0]     dir_in, dir_ff;
   logic signed [PT_W:0]   org_diff [3];
   logic signed [T_W:0]    dir_diff [3];

   always_comb begin
      transmitted_in = !h_ff.tir;
      for (int c = 0; c < 3; c++) begin
         org_diff[c] = (PT_W+1)'($signed(h_ff.hit[c])) - (PT_W+1)'($signed(h_ff.off[c]));
         dir_diff[c] = (T_W+1)'($signed(h_ff.term[c])) - (T_W+1)'($signed(h_ff.t2[c]));
         if (h_ff.tir) begin
            origin_in[c] = '0;
         end else if (org_diff[c][PT_W] != org_diff[c][PT_W-1]) begin
            origin_in[c] = org_diff[c][PT_W] ? {1'b1, {(PT_W-1){1'b0}}}
                                             : {1'b0, {(PT_W-1){1'b1}}};
         end else begin
            origin_in[c] = org_diff[c][PT_W-1:0];
         end
         if (h_ff.tir) begin
            dir_in[c] = '0;
         end else if (!((&dir_diff[c][T_W:DW-1]) || !(|dir_diff[c][T_W:DW-1]))) begin
            dir_in[c] = dir_diff[c][T_W] ? {1'b1, {(DW-1){1'b0}}}
                                         : {1'b0, {(DW-1){1'b1}}};
         end else begin
            dir_in[c] = dir_diff[c][DW-1:0];
         end
      end
   end

   // Valid bits for all stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= req_if.valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= div_valid;
         h_valid_ff   <= sq_valid;
         out_valid_ff <= h_valid_ff;
      end
   end

   // Payload for all stage registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff           <= a_in;
         b_ff           <= b_in;
         c_ff           <= c_in;
         d_ff           <= d_in;
         e_ff           <= e_in;
         f_ff           <= f_in;
         g_ff           <= g_in;
         x_ff           <= x_in;
         h_ff           <= h_in;
         transmitted_ff <= transmitted_in;
         origin_ff      <= origin_in;
         dir_ff         <= dir_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.transmitted = transmitted_ff;
   assign rsp_if.origin_x    = origin_ff[0];
   assign rsp_if.origin_y    = origin_ff[1];
   assign rsp_if.origin_z    = origin_ff[2];
   assign rsp_if.dir_x       = dir_ff[0];
   assign rsp_if.dir_y       = dir_ff[1];
   assign rsp_if.dir_z       = dir_ff[2];

   // A reflected ray carries no origin or direction.
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.transmitted |->
         rsp_if.origin_x == '0 && rsp_if.origin_y == '0 && rsp_if.origin_z == '0 &&
         rsp_if.dir_x == '0 && rsp_if.dir_y == '0 && rsp_if.dir_z == '0)
      else $error("reflected ray with nonzero payload");

   // A held response freezes the whole pipeline, including the request side.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("request accepted while response is held");

   // No response straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule
`default_nettype wire

FILE: tb/refraction_checker.sv
// Observes both ray channels, predicts each refracted ray and compares it with the response.
`default_nettype none
module refraction_checker #(
   parameter int DIR_FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [rrg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rrg_pkg::CSR_W-1:0]       csr_write_data,
   rrg_req_if                                   req,
   rrg_rsp_if                                   rsp,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   rays_checked,
   output int                                   tir_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int F     = DIR_FRAC_BITS;
   localparam int DIR_W = DIR_FRAC_BITS + 2;

   typedef struct {
      logic              transmitted;
      logic [31:0]       origin[3];
      logic [DIR_W-1:0]  dir[3];
   } ray_type;

   ray_type expected_rays[$];
   longint outer_index_q;
   longint offset_bias_q;

   // Saturate a value to a signed field of the given width.
   function automatic longint clamp_signed(input longint x, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (x > hi) ? hi : ((x < lo) ? lo : x);
   endfunction

   // Integer square root, rounded down.
   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Snell's law transmission in the block's fixed-point formats.
   function automatic ray_type refract(input longint nv[3], input longint iv[3],
                                       input longint hv[3], input longint mat);
      ray_type ray;
      longint one;
      longint d;
      longint ni;
      longint nt;
      longint d2;
      longint s;
      longint mag;
      longint q;
      longint k;
      longint sk;
      longint off;
      longint v;
      longint term;
      one = longint'(1) <<< F;
      d = 0;
      for (int c = 0; c < 3; c++) d += (iv[c] * nv[c]) >>> F;
      // Entering keeps the normal; leaving flips it and swaps the indices.
      if (d < 0) begin
         d  = -d;
         ni = outer_index_q;
         nt = mat;
      end else begin
         for (int c = 0; c < 3; c++) nv[c] = -nv[c];
         ni = mat;
         nt = outer_index_q;
      end
      if (nt == 0) nt = 1;
      if (d > 2 * one) d = 2 * one;
      d2  = (d * d) >>> F;
      s   = one - d2;
      mag = (s < 0) ? -s : s;
      q   = (ni * ni * mag) / (nt * nt);
      if (q > 8 * one) q = 8 * one;
      k = (s >= 0) ? one - q : one + q;
      ray.transmitted = (k >= 0);
      for (int c = 0; c < 3; c++) begin
         ray.origin[c] = '0;
         ray.dir[c]    = '0;
      end
      if (k < 0) return ray;
      sk = longint'(root_floor(longint'(unsigned'(k)) << F));
      for (int c = 0; c < 3; c++) begin
         off  = (offset_bias_q * nv[c]) >>> F;
         ray.origin[c] = 32'(clamp_signed(hv[c] - off, 32));
         v    = iv[c] + ((d * nv[c]) >>> F);
         term = (ni * v) / nt;
         ray.dir[c] = DIR_W'(clamp_signed(term - ((sk * nv[c]) >>> F), DIR_W));
      end
      return ray;
   endfunction

   // Report one field mismatch.
   function automatic void report(input string field, input longint want, input longint got);
      $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
   endfunction

   initial begin
      fail_count   = 0;
      pending      = 0;
      rays_checked = 0;
      tir_count    = 0;
   end

   // Track registers, queue predictions and compare responses.
   always @(posedge clock) begin
      longint  nv[3];
      longint  iv[3];
      longint  hv[3];
      ray_type want;
      if (reset) begin
         outer_index_q = rrg_pkg::OUTER_INDEX_RESET;
         offset_bias_q = rrg_pkg::OFFSET_BIAS_RESET;
         expected_rays.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == rrg_pkg::CSR_OUTER_INDEX)
               outer_index_q = csr_write_data[rrg_pkg::IDX_W-1:0];
            else if (csr_index == rrg_pkg::CSR_OFFSET_BIAS)
               offset_bias_q = csr_write_data[rrg_pkg::BIAS_W-1:0];
         end
         if (req.valid && req.ready) begin
            nv[0] = $signed(req.normal_x);   nv[1] = $signed(req.normal_y);
            nv[2] = $signed(req.normal_z);
            iv[0] = $signed(req.incident_x); iv[1] = $signed(req.incident_y);
            iv[2] = $signed(req.incident_z);
            hv[0] = $signed(req.hit_x);      hv[1] = $signed(req.hit_y);
            hv[2] = $signed(req.hit_z);
            expected_rays.push_back(refract(nv, iv, hv, longint'(req.material_index)));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_rays.size() == 0) begin
               $display("%0t ns: response transaction with no ray expected", $time);
               fail_count++;
            end else begin
               want = expected_rays.pop_front();
               rays_checked++;
               if (!want.transmitted) tir_count++;
               if (rsp.transmitted !== want.transmitted)
                  report("transmitted", want.transmitted, rsp.transmitted);
               if (rsp.origin_x !== want.origin[0])
                  report("origin_x", $signed(want.origin[0]), $signed(rsp.origin_x));
               if (rsp.origin_y !== want.origin[1])
                  report("origin_y", $signed(want.origin[1]), $signed(rsp.origin_y));
               if (rsp.origin_z !== want.origin[2])
                  report("origin_z", $signed(want.origin[2]), $signed(rsp.origin_z));
               if (rsp.dir_x !== want.dir[0])
                  report("dir_x", $signed(want.dir[0]), $signed(rsp.dir_x));
               if (rsp.dir_y !== want.dir[1])
                  report("dir_y", $signed(want.dir[1]), $signed(rsp.dir_y));
               if (rsp.dir_z !== want.dir[2])
                  report("dir_z", $signed(want.dir[2]), $signed(rsp.dir_z));
            end
         end
      end
      pending = expected_rays.size();
   end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Top of the refraction ray generator testbench: clock, reset, stimulus and verdict.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int F     = 16;
   localparam int DIR_W = F + 2;
   localparam int LATENCY = 2 * F + 16;

   typedef struct {
      logic [DIR_W-1:0] nrm[3];
      logic [DIR_W-1:0] inc[3];
      logic [31:0]      hit[3];
      logic [15:0]      mat;
   } surface_hit_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [rrg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rrg_pkg::CSR_W-1:0]       csr_write_data;
   int   fail_count;
   int   pending;
   int   rays_checked;
   int   tir_count;
   int   hits_sent = 0;
   bit   quiet = 1'b0;
   bit   hold_off = 1'b0;

   rrg_req_if #(.DIR_FRAC_BITS(F)) req_if ();
   rrg_rsp_if #(.DIR_FRAC_BITS(F)) rsp_if ();

   refraction_ray_generator_unit #(.DIR_FRAC_BITS(F)) DUT (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req_if(req_if), .rsp_if(rsp_if)
   );

   refraction_checker #(.DIR_FRAC_BITS(F)) u_checker (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .req(req_if), .rsp(rsp_if), .fail_count(fail_count), .pending(pending),
      .rays_checked(rays_checked), .tir_count(tir_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Overall time limit.
   initial begin
      #1_000_000;
      $display("Timeout with %0d rays outstanding", pending);
      $display("FAIL refraction_ray_generator_unit");
      $finish;
   end

   // Offer one hit, after an optional random gap, and wait for its transaction.
   task automatic send_hit(input surface_hit_type h);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.normal_x   <= h.nrm[0]; req_if.normal_y   <= h.nrm[1];
      req_if.normal_z   <= h.nrm[2];
      req_if.incident_x <= h.inc[0]; req_if.incident_y <= h.inc[1];
      req_if.incident_z <= h.inc[2];
      req_if.hit_x      <= h.hit[0]; req_if.hit_y      <= h.hit[1];
      req_if.hit_z      <= h.hit[2];
      req_if.material_index <= h.mat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      hits_sent++;
   endtask

   // Drain the pipeline, then write both registers.
   task automatic set_registers(input logic [15:0] outer, input logic [16:0] bias);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= rrg_pkg::CSR_OUTER_INDEX;
      csr_write_data   <= 17'(outer);
      @(posedge clock);
      csr_index        <= rrg_pkg::CSR_OFFSET_BIAS;
      csr_write_data   <= bias;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic surface_hit_type make_hit(input int nx, ny, nz, ix, iy, iz,
                                                input int hx, hy, hz, input int mat);
      surface_hit_type h;
      h.nrm[0] = DIR_W'(nx); h.nrm[1] = DIR_W'(ny); h.nrm[2] = DIR_W'(nz);
      h.inc[0] = DIR_W'(ix); h.inc[1] = DIR_W'(iy); h.inc[2] = DIR_W'(iz);
      h.hit[0] = hx;         h.hit[1] = hy;         h.hit[2] = hz;
      h.mat    = 16'(mat);
      return h;
   endfunction

   // Mostly near-unit geometry with plausible indices; the rest raw bits.
   function automatic surface_hit_type random_hit();
      surface_hit_type h;
      for (int c = 0; c < 3; c++) begin
         h.hit[c] = $urandom;
         if ($urandom_range(0, 9) < 7) begin
            h.nrm[c] = DIR_W'($urandom_range(0, 92682) - 46341);
            h.inc[c] = DIR_W'($urandom_range(0, 92682) - 46341);
         end else begin
            h.nrm[c] = DIR_W'($urandom);
            h.inc[c] = DIR_W'($urandom);
         end
      end
      h.mat = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(3000, 12000))
                                          : 16'($urandom_range(1, 65535));
      return h;
   endfunction

   // Response side: random stalls, one long hold-off, none at the end.
   initial begin
      bit held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (4 * LATENCY) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [15:0] outer_set[5];
      logic [16:0] bias_set[5];
      surface_hit_type directed[$];
      outer_set = '{16'd4096, 16'd1, 16'd65535, 16'd6144, 16'($urandom_range(2048, 8192))};
      bias_set  = '{17'd7, 17'd0, 17'd65536, 17'd131071, 17'($urandom_range(0, 65536))};
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= rrg_pkg::CSR_OUTER_INDEX;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.normal_x  <= '0; req_if.normal_y <= '0; req_if.normal_z <= '0;
      req_if.incident_x <= '0; req_if.incident_y <= '0; req_if.incident_z <= '0;
      req_if.hit_x <= '0; req_if.hit_y <= '0; req_if.hit_z <= '0;
      req_if.material_index <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Head-on entry, oblique entry, exit with and without total internal reflection.
      directed.push_back(make_hit(0, 0, 65536, 0, 0, -65536, 100, -200, 300, 6144));
      directed.push_back(make_hit(0, 0, 65536, 46341, 0, -46341, 0, 0, 0, 6144));
      directed.push_back(make_hit(0, 0, 65536, 60000, 0, 26000, 0, 0, 0, 6144));
      directed.push_back(make_hit(0, 0, 65536, 0, 0, 65536, 0, 0, 0, 6144));
      directed.push_back(make_hit(0, 65536, 0, 0, 46341, 46341, 0, 0, 0, 8192));
      // Zero material index as numerator and as divisor.
      directed.push_back(make_hit(0, 0, 65536, 0, 20000, 62000, 5, 5, 5, 0));
      directed.push_back(make_hit(0, 0, 65536, 0, 20000, -62000, 5, 5, 5, 0));
      // Field extremes and non-unit vectors that saturate the dot product.
      directed.push_back(make_hit(131071, 131071, 131071, 131071, 131071, 131071,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65535));
      directed.push_back(make_hit(-131072, -131072, -131072, -131072, -131072, -131072,
                                  32'h80000000, 32'h80000000, 32'h80000000, 1));
      directed.push_back(make_hit(131071, -131072, 131071, -131072, 131071, -131072,
                                  32'h80000000, 32'h7fffffff, 0, 65535));
      directed.push_back(make_hit(-131072, 131071, 0, 131071, 131071, 0,
                                  32'h7fffffff, 32'h80000000, -1, 1));
      directed.push_back(make_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 4096));
      directed.push_back(make_hit(0, 0, -65536, 0, 0, -65536, -1, -1, -1, 65535));
      directed.push_back(make_hit(0, 0, -65536, 65536, 0, 0, 0, 0, 0, 1));
      foreach (directed[i]) send_hit(directed[i]);

      // Random rays under several register settings.
      for (int p = 0; p < 5; p++) begin
         set_registers(outer_set[p], bias_set[p]);
         if (p == 1) hold_off = 1'b1;
         if (p == 4) quiet = 1'b1;
         repeat (327) send_hit(random_hit());
      end
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d hits over 5 register settings; %0d rays checked, %0d reflected",
               hits_sent, rays_checked, tir_count);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS refraction_ray_generator_unit");
      end else begin
         $display("FAIL refraction_ray_generator_unit");
      end
      $finish;
   end
endmodule
`default_nettype wire
